### sv/mlca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// mlca_pkg
// shared types and constants of the multi-lag correlation accumulator
// ------------------------------------------------------------------------
package mlca_pkg;

    localparam int MAX_PARTICLES_DEF = 256;
    localparam int MAX_LAGS_DEF      = 32;

    localparam int PC_W    = 9;
    localparam int LC_W    = 6;
    localparam int FLD_W   = 16;
    localparam int LAG_W   = 5;
    localparam int SUM_W   = 64;
    localparam int CNT_W   = 48;
    localparam int ENT_W   = 3 * SUM_W + CNT_W;

    localparam logic [PC_W-1:0] PC_RESET = 9'd256;
    localparam logic [LC_W-1:0] LC_RESET = 6'd32;

    // fixed-point sine constants, q30 (DIR_ONE and QUARTER are 2^14)
    localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'd1073741824;
    localparam logic [14:0] DIR_ONE     = 15'd16384;
    localparam logic [14:0] QUARTER     = 15'd16384;

    // exact reciprocals ceil(2^(32+l)/d) for dividends below 2^32
    localparam logic [32:0] RCP_72 = 33'd7635497416;
    localparam logic [32:0] RCP_42 = 33'd6544712071;
    localparam logic [32:0] RCP_20 = 33'd6871947674;
    localparam logic [32:0] RCP_6  = 33'd5726623062;

    typedef enum logic {
        CFG_PCOUNT,
        CFG_LCOUNT
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIN,
        ST_WR,
        ST_LAG,
        ST_DRAIN,
        ST_ERD,
        ST_ELD
    } t_state;

    typedef enum logic [3:0] {
        SS_X,
        SS_X2,
        SS_DIV72,
        SS_MUL1,
        SS_DIV42,
        SS_MUL2,
        SS_DIV20,
        SS_MUL3,
        SS_DIV6,
        SS_FIN
    } t_sin_step;

endpackage

`default_nettype wire

### sv/multi_lag_correlation_accumulator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// multi_lag_correlation_accumulator_top
// per-lag velocity/force/direction time correlation sums over a frame ring
// ------------------------------------------------------------------------
// usage:
// one item per particle (heading, velocity, force), particle_count items
// make a frame. input channel i_valid/o_ready, result channel o_valid/i_ready,
// config channel i_cfg_valid/o_cfg_ready with a register index and data.
// each item passes, from acceptance to the next acceptance, through the
// shared sine multiplier (two sines, ten multiply steps each), one ring
// write, one lag per cycle through a three stage read-modify-write of
// the sum memory for each valid lag, a drain of that pipeline and the
// idle state. after the last item of a frame one result per valid lag
// follows (sum memory read, count update and output load).
// results sit in an output register; a stalled receiver holds the emit
// sequence, and the next item is taken once the last result is loaded.
// reset and any config write clear sums, counts, ring head, frame count and
// particle position at once (valid bits per lag, no clearing pass).
// config is taken only while the block is idle.
// ------------------------------------------------------------------------
module multi_lag_correlation_accumulator_top
    import mlca_pkg::*;
#(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
    parameter int MAX_LAGS      = MAX_LAGS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic        [FLD_W-1:0]  i_heading,
    input  wire logic signed [FLD_W-1:0]  i_vel_x,
    input  wire logic signed [FLD_W-1:0]  i_vel_y,
    input  wire logic signed [FLD_W-1:0]  i_force_x,
    input  wire logic signed [FLD_W-1:0]  i_force_y,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic        [LAG_W-1:0]       o_lag_index,
    output logic signed [SUM_W-1:0]       o_sum_vel_dir,
    output logic signed [SUM_W-1:0]       o_sum_force_dir,
    output logic signed [SUM_W-1:0]       o_sum_vel_vel,
    output logic        [CNT_W-1:0]       o_pair_count,
    output logic                          o_last_lag,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic                     i_cfg_index,
    input  wire logic   [PC_W-1:0]        i_cfg_data
);

    localparam int PW   = $clog2(MAX_PARTICLES + 1);
    localparam int PSW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int LW   = $clog2(MAX_LAGS + 1);
    localparam int KW   = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;
    localparam int RD   = MAX_PARTICLES * MAX_LAGS;
    localparam int RAW  = (RD > 1) ? $clog2(RD) : 1;

    // memories
    logic [63:0]      r_ring [RD];
    logic [ENT_W-1:0] r_sums [MAX_LAGS];
    logic [63:0]      r_rdat;
    logic [ENT_W-1:0] r_sdat;
    logic             r_sdat_vld;
    logic [MAX_LAGS-1:0] r_lvld;

    t_state    r_state, n_state;
    t_sin_step r_step;
    logic      r_ph, r_sel;

    logic [PC_W-1:0] r_pcount;
    logic [LC_W-1:0] r_lcount;
    logic [PSW-1:0]  r_pos;
    logic [KW-1:0]   r_head, r_k, r_slot;
    logic [LW-1:0]   r_frames, r_valid;

    logic [FLD_W-1:0]        r_heading;
    logic signed [FLD_W-1:0] r_vx, r_vy, r_fx, r_fy;

    logic [65:0] r_prod;
    logic [30:0] r_x, r_p;
    logic [31:0] r_x2, r_a;
    logic [14:0] r_sin, r_cos;

    logic        r_s1_vld, r_s2_vld;
    logic [KW-1:0] r_s1_k, r_s2_k;
    logic signed [31:0] r_pvn0, r_pvn1, r_pfn0, r_pfn1, r_pvv0, r_pvv1;
    logic [ENT_W-1:0]   r_s2_ent;

    logic               r_ovld;
    logic [LAG_W-1:0]   r_olag;
    logic signed [SUM_W-1:0] r_ovd, r_ofd, r_ovv;
    logic [CNT_W-1:0]   r_ocnt;
    logic               r_olast;

    logic [PW-1:0] np;
    logic [LW-1:0] nl;
    logic          in_acc, cfg_acc, out_free, lag_last, emit_last, frame_end;
    logic [32:0]   mul_a, mul_b;
    logic [65:0]   mul_p;
    logic [14:0]   t_op;
    logic [31:0]   q_div;
    logic [15:0]   s_rnd;
    logic [14:0]   s_clamp;
    logic signed [FLD_W-1:0] nx, ny, sn, cs;
    logic [RAW-1:0] ring_wa, ring_ra;
    logic [LW:0]   valid_n;
    logic signed [FLD_W-1:0] pnx, pny, pvx, pvy;
    logic signed [32:0] d_vn, d_fn, d_vv;
    logic [ENT_W-1:0] s2_new, e_old, e_new;
    logic [CNT_W:0]   cnt_sum;

    function automatic logic signed [SUM_W-1:0] f_sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [32:0]      b
    );
        logic signed [SUM_W:0] t;
        t = (SUM_W+1)'(a) + (SUM_W+1)'(b);
        if (t[SUM_W] != t[SUM_W-1]) begin
            f_sat_add = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            f_sat_add = t[SUM_W-1:0];
        end
    endfunction

    // effective register values
    always_comb begin
        if (r_pcount == '0) begin
            np = PW'(1);
        end else if (int'(r_pcount) > MAX_PARTICLES) begin
            np = PW'(MAX_PARTICLES);
        end else begin
            np = PW'(r_pcount);
        end
        if (r_lcount == '0) begin
            nl = LW'(1);
        end else if (int'(r_lcount) > MAX_LAGS) begin
            nl = LW'(MAX_LAGS);
        end else begin
            nl = LW'(r_lcount);
        end
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign in_acc      = i_valid && o_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_ovld || i_ready;
    assign lag_last    = (LW'(r_k) + LW'(1)) == r_valid;
    assign emit_last   = lag_last;
    assign frame_end   = (PW'(r_pos) + PW'(1)) == np;

    // shared sine multiplier operands
    assign t_op = r_sel ? (QUARTER - {1'b0, r_heading[13:0]}) : {1'b0, r_heading[13:0]};
    always_comb begin
        unique case (r_step)
            SS_X:     begin mul_a = 33'(t_op); mul_b = HALF_PI_Q30; end
            SS_X2:    begin mul_a = 33'(r_x);  mul_b = 33'(r_x);    end
            SS_DIV72: begin mul_a = 33'(r_a);  mul_b = RCP_72;      end
            SS_DIV42: begin mul_a = 33'(r_a);  mul_b = RCP_42;      end
            SS_DIV20: begin mul_a = 33'(r_a);  mul_b = RCP_20;      end
            SS_DIV6:  begin mul_a = 33'(r_a);  mul_b = RCP_6;       end
            SS_MUL1, SS_MUL2, SS_MUL3: begin mul_a = 33'(r_x2); mul_b = 33'(r_p); end
            SS_FIN:   begin mul_a = 33'(r_x);  mul_b = 33'(r_p);    end
            default:  begin mul_a = '0;        mul_b = '0;          end
        endcase
    end
    assign mul_p = 66'(mul_a) * 66'(mul_b);

    always_comb begin
        unique case (r_step)
            SS_DIV72: q_div = 32'(r_prod >> 39);
            SS_DIV42: q_div = 32'(r_prod >> 38);
            SS_DIV20: q_div = 32'(r_prod >> 37);
            default:  q_div = 32'(r_prod >> 35);
        endcase
        s_rnd   = 16'((r_prod[60:30] + 31'd32768) >> 16);
        s_clamp = (s_rnd > 16'(DIR_ONE)) ? DIR_ONE : s_rnd[14:0];
    end

    // quadrant mapping
    assign sn = $signed({1'b0, r_sin});
    assign cs = $signed({1'b0, r_cos});
    always_comb begin
        unique case (r_heading[15:14])
            2'd0:    begin nx = cs;  ny = sn;  end
            2'd1:    begin nx = -sn; ny = cs;  end
            2'd2:    begin nx = -cs; ny = -sn; end
            default: begin nx = sn;  ny = -cs; end
        endcase
    end

    assign ring_wa = RAW'(r_head) * RAW'(MAX_PARTICLES) + RAW'(r_pos);
    assign ring_ra = RAW'(r_slot) * RAW'(MAX_PARTICLES) + RAW'(r_pos);
    assign valid_n = ((LW+1)'(r_frames) + (LW+1)'(1) < (LW+1)'(nl)) ?
                     (LW+1)'(r_frames) + (LW+1)'(1) : (LW+1)'(nl);

    // lag pipeline operands and update
    assign pnx = $signed(r_rdat[15:0]);
    assign pny = $signed(r_rdat[31:16]);
    assign pvx = $signed(r_rdat[47:32]);
    assign pvy = $signed(r_rdat[63:48]);
    assign d_vn = 33'(r_pvn0) + 33'(r_pvn1);
    assign d_fn = 33'(r_pfn0) + 33'(r_pfn1);
    assign d_vv = 33'(r_pvv0) + 33'(r_pvv1);
    assign s2_new = {r_s2_ent[ENT_W-1:3*SUM_W],
                     f_sat_add($signed(r_s2_ent[3*SUM_W-1:2*SUM_W]), d_vv),
                     f_sat_add($signed(r_s2_ent[2*SUM_W-1:SUM_W]), d_fn),
                     f_sat_add($signed(r_s2_ent[SUM_W-1:0]), d_vn)};

    // frame-end count update
    assign e_old   = r_sdat_vld ? r_sdat : '0;
    assign cnt_sum = (CNT_W+1)'(e_old[ENT_W-1:3*SUM_W]) + (CNT_W+1)'(np);
    assign e_new   = {cnt_sum[CNT_W] ? {CNT_W{1'b1}} : cnt_sum[CNT_W-1:0],
                      e_old[3*SUM_W-1:0]};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_acc) n_state = ST_SIN;
            ST_SIN:   if (r_ph && r_step == SS_FIN && r_sel) n_state = ST_WR;
            ST_WR:    n_state = ST_LAG;
            ST_LAG:   if (lag_last) n_state = ST_DRAIN;
            ST_DRAIN: begin
                if (!r_s1_vld && !r_s2_vld) begin
                    n_state = frame_end ? ST_ERD : ST_IDLE;
                end
            end
            ST_ERD:   n_state = ST_ELD;
            ST_ELD: begin
                if (out_free) n_state = emit_last ? ST_IDLE : ST_ERD;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= SS_X;
            r_ph     <= 1'b0;
            r_sel    <= 1'b0;
            r_pcount <= PC_RESET;
            r_lcount <= LC_RESET;
            r_pos    <= '0;
            r_head   <= '0;
            r_frames <= '0;
            r_lvld   <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_ovld   <= 1'b0;
            r_k      <= '0;
            r_slot   <= '0;
            r_valid  <= '0;
        end else begin
            if (o_valid && i_ready && r_state != ST_ELD) r_ovld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= r_s1_vld;

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_step <= SS_X;
                        r_ph   <= 1'b0;
                        r_sel  <= 1'b0;
                        if (r_pos == '0 && r_frames != '0 && !cfg_acc) begin
                            r_head <= (LW'(r_head) + LW'(1) == nl) ? '0 : r_head + 1'b1;
                        end
                    end
                end
                ST_SIN: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (r_step == SS_FIN) begin
                            r_step <= SS_X;
                            r_sel  <= 1'b1;
                        end else begin
                            r_step <= t_sin_step'(r_step + 1'b1);
                        end
                    end
                end
                ST_WR: begin
                    r_k     <= '0;
                    r_slot  <= r_head;
                    r_valid <= LW'(valid_n);
                end
                ST_LAG: begin
                    r_s1_vld <= 1'b1;
                    r_k      <= r_k + 1'b1;
                    r_slot   <= (r_slot == '0) ? KW'(nl - LW'(1)) : r_slot - 1'b1;
                end
                ST_DRAIN: begin
                    if (!r_s1_vld && !r_s2_vld) begin
                        r_k <= '0;
                        if (frame_end) begin
                            r_pos <= '0;
                            if (r_frames < nl) r_frames <= r_frames + 1'b1;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                end
                ST_ERD: begin
                end
                ST_ELD: begin
                    if (out_free) begin
                        r_ovld <= 1'b1;
                        r_lvld[r_k] <= 1'b1;
                        r_k <= r_k + 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (r_s2_vld) r_lvld[r_s2_k] <= 1'b1;

            if (cfg_acc) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_PCOUNT: r_pcount <= i_cfg_data;
                    CFG_LCOUNT: r_lcount <= i_cfg_data[LC_W-1:0];
                    default:    r_pcount <= i_cfg_data;
                endcase
                r_lvld   <= '0;
                r_head   <= '0;
                r_frames <= '0;
                r_pos    <= '0;
            end
        end
    end

    // sine datapath and item registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_heading <= i_heading;
            r_vx <= i_vel_x;
            r_vy <= i_vel_y;
            r_fx <= i_force_x;
            r_fy <= i_force_y;
        end
        if (r_state == ST_SIN) begin
            if (!r_ph) begin
                r_prod <= mul_p;
            end else begin
                unique case (r_step)
                    SS_X:  r_x <= r_prod[44:14];
                    SS_X2: begin
                        r_x2 <= r_prod[61:30];
                        r_a  <= r_prod[61:30];
                    end
                    SS_DIV72, SS_DIV42, SS_DIV20, SS_DIV6: r_p <= Q30_ONE - q_div[30:0];
                    SS_MUL1, SS_MUL2, SS_MUL3: r_a <= r_prod[61:30];
                    SS_FIN: begin
                        if (r_sel) r_cos <= s_clamp;
                        else       r_sin <= s_clamp;
                    end
                    default: r_a <= r_a;
                endcase
            end
        end
        // product stage of the lag pipeline
        r_s1_k <= r_k;
        r_s2_k <= r_s1_k;
        r_pvn0 <= r_vx * pnx;
        r_pvn1 <= r_vy * pny;
        r_pfn0 <= r_fx * pnx;
        r_pfn1 <= r_fy * pny;
        r_pvv0 <= r_vx * pvx;
        r_pvv1 <= r_vy * pvy;
        r_s2_ent <= r_sdat_vld ? r_sdat : '0;
        // output register payload
        if (r_state == ST_ELD && out_free) begin
            r_olag  <= LAG_W'(r_k);
            r_ovd   <= $signed(e_old[SUM_W-1:0]);
            r_ofd   <= $signed(e_old[2*SUM_W-1:SUM_W]);
            r_ovv   <= $signed(e_old[3*SUM_W-1:2*SUM_W]);
            r_ocnt  <= e_new[ENT_W-1:3*SUM_W];
            r_olast <= emit_last;
        end
    end

    // history ring
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WR) begin
            r_ring[ring_wa] <= {r_vy, r_vx, ny, nx};
        end
        if (r_state == ST_LAG) begin
            r_rdat <= r_ring[ring_ra];
        end
    end

    // per-lag sums and counts
    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_sums[r_s2_k] <= s2_new;
        end else if (r_state == ST_ELD && out_free) begin
            r_sums[r_k] <= e_new;
        end
        if (r_state == ST_LAG || r_state == ST_ERD) begin
            r_sdat     <= r_sums[r_k];
            r_sdat_vld <= r_lvld[r_k];
        end
    end

    assign o_valid         = r_ovld;
    assign o_lag_index     = r_olag;
    assign o_sum_vel_dir   = r_ovd;
    assign o_sum_force_dir = r_ofd;
    assign o_sum_vel_vel   = r_ovv;
    assign o_pair_count    = r_ocnt;
    assign o_last_lag      = r_olast;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(r_pos) < np)
        else $error("particle position beyond frame size");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_head) < nl)
        else $error("ring head beyond lag count");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LAG) |-> (LW'(r_slot) < nl && LW'(r_k) < r_valid))
        else $error("lag loop outside valid lags");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld || r_s2_vld) |-> !o_ready)
        else $error("item accepted while lag pipeline busy");

    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ELD && out_free && emit_last) |=> (o_valid && o_last_lag))
        else $error("final lag result not flagged");

endmodule

`default_nettype wire
